FILE: rtl/alv_pkg.sv
// ----------------------------------------------------------------------------
// Action list validator package
// Shared constants, verdict codes and the checker result type.
// ----------------------------------------------------------------------------
package alv_pkg;

  localparam int unsigned BUILTIN_TYPES_DEF = 10;
  localparam int unsigned FieldW            = 16;

  localparam logic [FieldW-1:0] HdrBytes   = 16'd8;
  localparam logic [FieldW-1:0] WideBytes  = 16'd16;
  localparam logic [FieldW-1:0] KindVendor = 16'hffff;
  localparam logic [FieldW-1:0] PortNone   = 16'hffff;
  localparam logic [FieldW-1:0] KindOutput = 16'd0;
  localparam logic [FieldW-1:0] KindDlSrc  = 16'd4;
  localparam logic [FieldW-1:0] KindDlDst  = 16'd5;

  typedef enum logic [2:0] {
    V_OK         = 3'd0,
    V_BAD_LEN    = 3'd1,
    V_BAD_TYPE   = 3'd2,
    V_BAD_VENDOR = 3'd3,
    V_BAD_PORT   = 3'd4
  } verdict_e;

  typedef struct packed {
    logic              has_result;
    verdict_e          verdict;
    logic              list_open;
    logic [FieldW-1:0] bytes_left;
  } alv_result_t;

endpackage

FILE: rtl/action_list_validator_unit.sv
// ----------------------------------------------------------------------------
// Action list validator
// Validates an action list one action header per request.
// ----------------------------------------------------------------------------
// The block takes one action header per cycle and gives at most one verdict
// per list. The header that decides a verdict passes through registers on its
// way to the output: the request is captured in an input register, checked
// against the running byte count, and the verdict lands in a result
// register. The byte count and the open-list flag are updated in the same
// cycle as the check, so back-to-back headers of one list are handled at full
// rate. The input stalls only while a verdict is pending in the result
// register and the next checked header would give another one.
module action_list_validator_unit
  import alv_pkg::*;
#(
  parameter int unsigned BuiltinTypes = BUILTIN_TYPES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              first_of_list_i,
  input  logic [FieldW-1:0] list_bytes_i,
  input  logic [FieldW-1:0] action_kind_i,
  input  logic [FieldW-1:0] action_bytes_i,
  input  logic [FieldW-1:0] target_port_i,
  input  logic [FieldW-1:0] ingress_port_i,
  input  logic              ingress_wild_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        verdict_o
);

  logic              s1_valid_q;
  logic              first_q;
  logic [FieldW-1:0] list_bytes_q;
  logic [FieldW-1:0] kind_q;
  logic [FieldW-1:0] act_bytes_q;
  logic [FieldW-1:0] target_q;
  logic [FieldW-1:0] ingress_q;
  logic              wild_q;

  logic              list_open_q;
  logic [FieldW-1:0] bytes_left_q;
  logic              out_valid_q;
  verdict_e          verdict_q;

  alv_result_t       res;
  logic              out_free;
  logic              s1_adv;
  logic              in_take;

  alv_check #(
    .BuiltinTypes(BuiltinTypes)
  ) u_check (
    .list_open_i    (list_open_q),
    .bytes_left_i   (bytes_left_q),
    .first_of_list_i(first_q),
    .list_bytes_i   (list_bytes_q),
    .action_kind_i  (kind_q),
    .action_bytes_i (act_bytes_q),
    .target_port_i  (target_q),
    .ingress_port_i (ingress_q),
    .ingress_wild_i (wild_q),
    .result_o       (res)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!res.has_result || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_take    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      list_open_q  <= 1'b0;
      bytes_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        list_open_q  <= res.list_open;
        bytes_left_q <= res.bytes_left;
      end
      if (s1_adv && res.has_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      first_q      <= first_of_list_i;
      list_bytes_q <= list_bytes_i;
      kind_q       <= action_kind_i;
      act_bytes_q  <= action_bytes_i;
      target_q     <= target_port_i;
      ingress_q    <= ingress_port_i;
      wild_q       <= ingress_wild_i;
    end
    if (s1_adv && res.has_result) begin
      verdict_q <= res.verdict;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  // An open list always has room for at least one more header.
  a_open_has_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    list_open_q |-> bytes_left_q >= HdrBytes)
    else $error("open list with fewer than eight bytes left");

  // A verdict closes the list.
  a_verdict_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && res.has_result |=> !list_open_q && out_valid_q)
    else $error("list still open after a verdict");

  // List state moves only when a checked header leaves the input register.
  a_state_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(list_open_q) && $stable(bytes_left_q))
    else $error("list state changed without a checked header");

  // The input stalls only behind a pending, untaken verdict.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled without a blocked verdict");

endmodule

FILE: rtl/alv_check.sv
// ----------------------------------------------------------------------------
// Action header checker
// Checks one action header against the running byte count and returns the
// verdict, if any, together with the next list state.
// ----------------------------------------------------------------------------
module alv_check
  import alv_pkg::*;
#(
  parameter int unsigned BuiltinTypes = BUILTIN_TYPES_DEF
) (
  input  logic              list_open_i,
  input  logic [FieldW-1:0] bytes_left_i,
  input  logic              first_of_list_i,
  input  logic [FieldW-1:0] list_bytes_i,
  input  logic [FieldW-1:0] action_kind_i,
  input  logic [FieldW-1:0] action_bytes_i,
  input  logic [FieldW-1:0] target_port_i,
  input  logic [FieldW-1:0] ingress_port_i,
  input  logic              ingress_wild_i,
  output alv_result_t       result_o
);

  logic [FieldW-1:0] base;
  logic [FieldW-1:0] remain;
  logic [FieldW-1:0] exact_size;
  verdict_e          act_verdict;

  assign base   = first_of_list_i ? list_bytes_i : bytes_left_i;
  assign remain = base - action_bytes_i;
  assign exact_size = (action_kind_i == KindDlSrc || action_kind_i == KindDlDst) ?
                      WideBytes : HdrBytes;

  always_comb begin
    if (base < action_bytes_i || action_bytes_i[2:0] != 3'd0) begin
      act_verdict = V_BAD_LEN;
    end else if (action_kind_i < FieldW'(BuiltinTypes)) begin
      if (action_bytes_i != exact_size) begin
        act_verdict = V_BAD_LEN;
      end else if (action_kind_i == KindOutput &&
                   (target_port_i == PortNone ||
                    (!ingress_wild_i && target_port_i == ingress_port_i))) begin
        act_verdict = V_BAD_PORT;
      end else begin
        act_verdict = V_OK;
      end
    end else if (action_kind_i == KindVendor) begin
      act_verdict = (action_bytes_i < HdrBytes) ? V_BAD_LEN : V_BAD_VENDOR;
    end else begin
      act_verdict = V_BAD_TYPE;
    end
  end

  always_comb begin
    result_o.has_result = 1'b0;
    result_o.verdict    = V_OK;
    result_o.list_open  = list_open_i;
    result_o.bytes_left = bytes_left_i;
    if (first_of_list_i && list_bytes_i < HdrBytes) begin
      // A list too short for any header closes at once without a check.
      result_o.has_result = 1'b1;
      result_o.verdict    = (list_bytes_i == '0) ? V_OK : V_BAD_LEN;
      result_o.list_open  = 1'b0;
      result_o.bytes_left = list_bytes_i;
    end else if (first_of_list_i || list_open_i) begin
      if (act_verdict != V_OK) begin
        result_o.has_result = 1'b1;
        result_o.verdict    = act_verdict;
        result_o.list_open  = 1'b0;
        result_o.bytes_left = base;
      end else if (remain < HdrBytes) begin
        result_o.has_result = 1'b1;
        result_o.verdict    = (remain == '0) ? V_OK : V_BAD_LEN;
        result_o.list_open  = 1'b0;
        result_o.bytes_left = remain;
      end else begin
        result_o.list_open  = 1'b1;
        result_o.bytes_left = remain;
      end
    end
  end

endmodule
